// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file.
// Each macro takes a label, an antecedent, a consequent and a message string.
// The checker that uses them must have ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/cmea_pkg.sv =====
`default_nettype none
package cmea_pkg;

   localparam int MAX_ITEMS     = 1024;
   localparam int ANGLE_BITS    = 16;
   localparam int TURN_BITS     = 24;
   localparam int CORDIC_STEPS  = 16;
   localparam int STEP_BITS     = $clog2(CORDIC_STEPS);
   localparam int COUNT_BITS    = $clog2(MAX_ITEMS + 1);
   localparam int TRANS_BITS    = 32;
   localparam int SUM_BITS      = 42;
   localparam int DIVIDEND_BITS = SUM_BITS + 1;
   localparam int REM_BITS      = COUNT_BITS + 1;
   localparam int SEQ_BITS      = 6;
   localparam int TRIG_BITS     = 18;
   localparam int TRIG_SUM_BITS = 28;
   localparam int XY_BITS       = 34;
   localparam int Z_BITS        = 26;
   localparam int CORDIC_X0     = 652032875;
   localparam int Q16_ONE       = 65536;
   localparam int ITEM_COUNT_BITS = 11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_ACCUM,
      ST_PREP,
      ST_DIVIDE,
      ST_VECTOR,
      ST_DONE
   } state_type;

   // Control of one CORDIC micro-rotation.
   typedef struct packed {
      logic                 ccw;
      logic [STEP_BITS-1:0] step;
   } cordic_ctl_type;

   // Arctangent of 2^-i in units of 2^24 per turn.
   function automatic logic signed [Z_BITS-1:0] atan_angle(input logic [STEP_BITS-1:0] idx);
      logic signed [Z_BITS-1:0] r;
      case (idx)
         4'd0:    r = Z_BITS'(2097152);
         4'd1:    r = Z_BITS'(1238021);
         4'd2:    r = Z_BITS'(654136);
         4'd3:    r = Z_BITS'(332050);
         4'd4:    r = Z_BITS'(166669);
         4'd5:    r = Z_BITS'(83416);
         4'd6:    r = Z_BITS'(41718);
         4'd7:    r = Z_BITS'(20860);
         4'd8:    r = Z_BITS'(10430);
         4'd9:    r = Z_BITS'(5215);
         4'd10:   r = Z_BITS'(2608);
         4'd11:   r = Z_BITS'(1304);
         4'd12:   r = Z_BITS'(652);
         4'd13:   r = Z_BITS'(326);
         4'd14:   r = Z_BITS'(163);
         default: r = Z_BITS'(81);
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cmea_cordic_step.sv =====
`default_nettype none
// One CORDIC micro-rotation, shared by the rotation and vectoring passes.
module cmea_cordic_step import cmea_pkg::*; (
   input  wire logic signed [XY_BITS-1:0] x_cur,
   input  wire logic signed [XY_BITS-1:0] y_cur,
   input  wire logic signed [Z_BITS-1:0]  z_cur,
   input  wire cordic_ctl_type            ctl,
   output logic signed [XY_BITS-1:0]      x_nxt,
   output logic signed [XY_BITS-1:0]      y_nxt,
   output logic signed [Z_BITS-1:0]       z_nxt
);

   logic signed [XY_BITS-1:0] dx;
   logic signed [XY_BITS-1:0] dy;
   logic signed [Z_BITS-1:0]  at;

   always_comb begin
      dx = y_cur >>> ctl.step;
      dy = x_cur >>> ctl.step;
      at = atan_angle(ctl.step);
      if (ctl.ccw) begin
         x_nxt = x_cur - dx;
         y_nxt = y_cur + dy;
         z_nxt = z_cur - at;
      end else begin
         x_nxt = x_cur + dx;
         y_nxt = y_cur - dy;
         z_nxt = z_cur + at;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/circular_mean_error_averager.sv =====
`default_nettype none
// Circular mean error averager. Each input transaction carries a Q16.16 translation
// error and a 16-bit binary angle (65536 is one turn); tuser says whether the pair is
// to be counted, and tlast ends the run. For every counted pair the block adds the
// translation to a running sum, and the sine and cosine of the angle (Q1.16, from a
// 16-step CORDIC) to two running sums, up to 1024 pairs; later pairs are dropped and
// reported by the overflow flag. A transaction with tlast produces one result
// transaction: the rounded mean translation, the circular mean angle (atan2 of the
// two sums, wrapped to one turn), the pair count and the overflow flag; an empty run
// gives zeros. The run state is then cleared. Sequence: a counted pair is accepted,
// then passes 16 iterations of the shared CORDIC unit and an accumulate step; other
// transactions need only the accept step. A transaction with tlast then adds a setup
// step, the 43 quotient bits of the bit-serial restoring divider, 16 vectoring
// iterations on the same CORDIC unit and the load of the result register, which waits
// for a held result to be taken; an empty run skips divider and vectoring. The input
// side is ready only while the sequencer is idle. The result register decouples the
// two sides, so a new run may start while the previous result still waits to be taken.
module circular_mean_error_averager import cmea_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata fields from bit 0: translation_error[31:0], rotation_angle[47:32]
   input  wire logic [47:0] req_tdata,
   // req_tuser fields from bit 0: carries_value
   input  wire logic        req_tuser,
   input  wire logic        req_tlast,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata fields from bit 0: mean_translation[31:0], mean_angle[47:32],
   // item_count[58:48], zero fill[63:59]
   output logic [63:0]      rsp_tdata,
   // rsp_tuser fields from bit 0: overflow_flag
   output logic             rsp_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);

   localparam int ANG_LSB = TRANS_BITS;
   localparam int CNT_LSB = TRANS_BITS + ANGLE_BITS;
   localparam int FILL_BITS = 64 - CNT_LSB - ITEM_COUNT_BITS;

   // Sequencer state.
   state_type                        state_ff, state_in;
   logic [SEQ_BITS-1:0]              cnt_ff, cnt_in;

   // Shared CORDIC working registers.
   logic signed [XY_BITS-1:0]        x_ff, x_in;
   logic signed [XY_BITS-1:0]        y_ff, y_in;
   logic signed [Z_BITS-1:0]         z_ff, z_in;
   logic [1:0]                       quad_ff, quad_in;

   // Captured transaction payload.
   logic [TRANS_BITS-1:0]            tr_ff, tr_in;
   logic                             last_ff, last_in;

   // Run state.
   logic [SUM_BITS-1:0]              tsum_ff, tsum_in;
   logic signed [TRIG_SUM_BITS-1:0]  ssum_ff, ssum_in;
   logic signed [TRIG_SUM_BITS-1:0]  csum_ff, csum_in;
   logic [COUNT_BITS-1:0]            count_ff, count_in;
   logic                             over_ff, over_in;

   // Divider registers: the dividend shifts out at the top while quotient bits enter.
   logic [DIVIDEND_BITS-1:0]         div_ff, div_in;
   logic [REM_BITS-1:0]              rem_ff, rem_in;

   // Result register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [TRANS_BITS-1:0]            rsp_mean_ff, rsp_mean_in;
   logic [ANGLE_BITS-1:0]            rsp_angle_ff, rsp_angle_in;
   logic [ITEM_COUNT_BITS-1:0]       rsp_count_ff, rsp_count_in;
   logic                             rsp_over_ff, rsp_over_in;

   cordic_ctl_type                   ctl;
   logic signed [XY_BITS-1:0]        x_nxt, y_nxt;
   logic signed [Z_BITS-1:0]         z_nxt;

   // Round Q3.30 to Q1.16 half up, then clamp to plus or minus one.
   function automatic logic signed [TRIG_BITS-1:0] to_q16(input logic signed [XY_BITS-1:0] v);
      logic signed [XY_BITS-1:0] r;
      r = (v + XY_BITS'(8192)) >>> 14;
      if (r > XY_BITS'(Q16_ONE)) begin
         r = XY_BITS'(Q16_ONE);
      end else if (r < -XY_BITS'(Q16_ONE)) begin
         r = -XY_BITS'(Q16_ONE);
      end
      return TRIG_BITS'(r);
   endfunction

   // The vectoring pass drives y toward zero; the rotation pass drives z toward zero.
   always_comb begin
      ctl.step = cnt_ff[STEP_BITS-1:0];
      if (state_ff == ST_VECTOR) begin
         ctl.ccw = !(y_ff > 0);
      end else begin
         ctl.ccw = !z_ff[Z_BITS-1];
      end
   end

   cmea_cordic_step u_step (
      .x_cur (x_ff),
      .y_cur (y_ff),
      .z_cur (z_ff),
      .ctl   (ctl),
      .x_nxt (x_nxt),
      .y_nxt (y_nxt),
      .z_nxt (z_nxt)
   );

   logic [TURN_BITS-1:0]             a_turn;
   logic signed [TRIG_BITS-1:0]      c_raw, s_raw, c_fold, s_fold;
   logic [REM_BITS-1:0]              trial;
   logic                             qbit;
   logic signed [XY_BITS-1:0]        xv, yv;
   logic [TURN_BITS:0]               z_round;
   logic [ANGLE_BITS-1:0]            angle_out;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      quad_in      = quad_ff;
      tr_in        = tr_ff;
      last_in      = last_ff;
      tsum_in      = tsum_ff;
      ssum_in      = ssum_ff;
      csum_in      = csum_ff;
      count_in     = count_ff;
      over_in      = over_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_count_in = rsp_count_ff;
      rsp_over_in  = rsp_over_ff;

      req_tready   = (state_ff == ST_IDLE);

      a_turn = {req_tdata[ANG_LSB +: ANGLE_BITS], {(TURN_BITS - ANGLE_BITS){1'b0}}};

      c_raw = to_q16(x_ff);
      s_raw = to_q16(y_ff);
      case (quad_ff)
         2'd0: begin
            c_fold = c_raw;
            s_fold = s_raw;
         end
         2'd1: begin
            c_fold = -s_raw;
            s_fold = c_raw;
         end
         2'd2: begin
            c_fold = -c_raw;
            s_fold = -s_raw;
         end
         default: begin
            c_fold = s_raw;
            s_fold = -c_raw;
         end
      endcase

      trial = {rem_ff[REM_BITS-2:0], div_ff[DIVIDEND_BITS-1]};
      qbit  = (trial >= REM_BITS'(count_ff));

      xv = {{(XY_BITS - TRIG_SUM_BITS){csum_ff[TRIG_SUM_BITS-1]}}, csum_ff} <<< 4;
      yv = {{(XY_BITS - TRIG_SUM_BITS){ssum_ff[TRIG_SUM_BITS-1]}}, ssum_ff} <<< 4;

      // Reduce modulo one turn, then round half up to the output angle width.
      z_round = {1'b0, z_ff[TURN_BITS-1:0]}
              + (TURN_BITS + 1)'(1 << (TURN_BITS - ANGLE_BITS - 1));
      if (ssum_ff == '0 && csum_ff == '0) begin
         angle_out = '0;
      end else begin
         angle_out = z_round[TURN_BITS-1 -: ANGLE_BITS];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               tr_in   = req_tdata[TRANS_BITS-1:0];
               last_in = req_tlast;
               quad_in = a_turn[TURN_BITS-1 -: 2];
               x_in    = XY_BITS'(CORDIC_X0);
               y_in    = '0;
               z_in    = '0;
               z_in[TURN_BITS-3:0] = a_turn[TURN_BITS-3:0];
               cnt_in  = '0;
               if (req_tuser && count_ff < COUNT_BITS'(MAX_ITEMS)) begin
                  state_in = ST_ROTATE;
               end else begin
                  if (req_tuser) begin
                     over_in = 1'b1;
                  end
                  if (req_tlast) begin
                     state_in = ST_PREP;
                  end
               end
            end
         end
         ST_ROTATE: begin
            x_in   = x_nxt;
            y_in   = y_nxt;
            z_in   = z_nxt;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SEQ_BITS'(CORDIC_STEPS - 1)) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            tsum_in  = tsum_ff + SUM_BITS'(tr_ff);
            ssum_in  = ssum_ff + {{(TRIG_SUM_BITS - TRIG_BITS){s_fold[TRIG_BITS-1]}}, s_fold};
            csum_in  = csum_ff + {{(TRIG_SUM_BITS - TRIG_BITS){c_fold[TRIG_BITS-1]}}, c_fold};
            count_in = count_ff + 1'b1;
            state_in = last_ff ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            // Adding half the count to the dividend rounds the quotient.
            div_in = DIVIDEND_BITS'(tsum_ff) + DIVIDEND_BITS'(count_ff >> 1);
            rem_in = '0;
            cnt_in = '0;
            state_in = (count_ff == '0) ? ST_DONE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in = qbit ? (trial - REM_BITS'(count_ff)) : trial;
            div_in = {div_ff[DIVIDEND_BITS-2:0], qbit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SEQ_BITS'(DIVIDEND_BITS - 1)) begin
               // Start vectoring on the scaled sums; a negative cosine sum is
               // turned by a half turn first.
               cnt_in   = '0;
               state_in = ST_VECTOR;
               if (xv < 0) begin
                  x_in = -xv;
                  y_in = -yv;
                  z_in = Z_BITS'(1 << (TURN_BITS - 1));
               end else begin
                  x_in = xv;
                  y_in = yv;
                  z_in = '0;
               end
            end
         end
         ST_VECTOR: begin
            x_in   = x_nxt;
            y_in   = y_nxt;
            z_in   = z_nxt;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SEQ_BITS'(CORDIC_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = (count_ff == '0) ? '0 : div_ff[TRANS_BITS-1:0];
               rsp_angle_in = angle_out;
               rsp_count_in = ITEM_COUNT_BITS'(count_ff);
               rsp_over_in  = over_ff;
               tsum_in      = '0;
               ssum_in      = '0;
               csum_in      = '0;
               count_in     = '0;
               over_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tsum_ff      <= '0;
         ssum_ff      <= '0;
         csum_ff      <= '0;
         count_ff     <= '0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tsum_ff      <= tsum_in;
         ssum_ff      <= ssum_in;
         csum_ff      <= csum_in;
         count_ff     <= count_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      quad_ff      <= quad_in;
      tr_ff        <= tr_in;
      last_ff      <= last_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_count_ff <= rsp_count_in;
      rsp_over_ff  <= rsp_over_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_over_ff;
   assign rsp_tdata  = {{FILL_BITS{1'b0}}, rsp_count_ff, rsp_angle_ff, rsp_mean_ff};

endmodule
`default_nettype wire

// ===== hw/rtl/cmea_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
// Port-level checks of the averager.
module cmea_checker import cmea_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic [47:0] req_tdata,
   input wire logic        req_tuser,
   input wire logic        req_tlast,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready
);

   logic rsp_stall;
   logic req_unused;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign req_unused = ^{req_tdata, req_tuser, req_tlast, req_tvalid, req_tready, rsp_tuser};

   `ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid, "result transaction dropped while stalled")
   `ASSERT_NEXT(a_rsp_stable, rsp_stall, $stable(rsp_tdata), "result data changed while stalled")
   `ASSERT_SAME(a_count_max, rsp_tvalid, rsp_tdata[58:48] <= 11'(MAX_ITEMS), "count above capacity")
   `ASSERT_SAME(a_empty_zero, rsp_tvalid && rsp_tdata[58:48] == 11'd0,
      rsp_tdata[47:0] == 48'd0, "empty run gave a nonzero mean")

endmodule

bind circular_mean_error_averager cmea_checker u_checker (.*);
`default_nettype wire
